// ===== design/sm83_pkg.sv =====
// package: shared types and constants for the sm83 load/alu executor
`timescale 1ns / 1ps
package sm83_pkg;
    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_IDLE  = 2'd2
    } t_kind;

    localparam logic [3:0] FZ = 4'b1000;
    localparam logic [3:0] FN = 4'b0100;
    localparam logic [3:0] FH = 4'b0010;
    localparam logic [3:0] FC = 4'b0001;

    localparam logic [15:0] HIGH_PAGE = 16'hFF00;

    localparam logic [1:0] REG_START_PC = 2'd0;
    localparam logic [1:0] REG_START_SP = 2'd1;

    typedef struct packed {
        logic [7:0] res;
        logic [3:0] flags;
    } t_alu_out;
endpackage

// ===== design/sm83_alu.sv =====
// module: 8-bit alu, inc/dec and daa datapath
`timescale 1ns / 1ps
module sm83_alu (
    input  logic [2:0]       i_kind,
    input  logic [7:0]       i_acc,
    input  logic [7:0]       i_val,
    input  logic [3:0]       i_flags,
    input  logic             i_dec,
    output sm83_pkg::t_alu_out o_alu,
    output sm83_pkg::t_alu_out o_incdec,
    output sm83_pkg::t_alu_out o_daa
);
    logic       cin;
    logic [8:0] sum;
    logic [4:0] hsum;
    logic [7:0] r;
    logic [3:0] f;
    logic [7:0] idr;
    logic [3:0] idf;
    logic [8:0] da;
    logic       dc;

    always_comb begin
        cin  = 1'b0;
        sum  = 9'd0;
        hsum = 5'd0;
        r    = 8'd0;
        f    = 4'd0;
        case (i_kind)
            3'd0, 3'd1: begin
                cin  = (i_kind == 3'd1) & i_flags[0];
                sum  = {1'b0, i_acc} + {1'b0, i_val} + {8'd0, cin};
                hsum = {1'b0, i_acc[3:0]} + {1'b0, i_val[3:0]} + {4'd0, cin};
                r    = sum[7:0];
                f    = (hsum[4] ? sm83_pkg::FH : 4'd0) | (sum[8] ? sm83_pkg::FC : 4'd0);
            end
            3'd2, 3'd3, 3'd7: begin
                cin  = (i_kind == 3'd3) & i_flags[0];
                sum  = {1'b0, i_acc} - {1'b0, i_val} - {8'd0, cin};
                hsum = {1'b0, i_acc[3:0]} - {1'b0, i_val[3:0]} - {4'd0, cin};
                r    = sum[7:0];
                f    = sm83_pkg::FN | (hsum[4] ? sm83_pkg::FH : 4'd0)
                     | (sum[8] ? sm83_pkg::FC : 4'd0);
            end
            3'd4: begin r = i_acc & i_val; f = sm83_pkg::FH; end
            3'd5: r = i_acc ^ i_val;
            default: r = i_acc | i_val;
        endcase
        if (r == 8'd0) f = f | sm83_pkg::FZ;
        o_alu = '{res: r, flags: f};

        // inc/dec keeps carry
        idr = i_dec ? i_val - 8'd1 : i_val + 8'd1;
        idf = i_flags & sm83_pkg::FC;
        if (i_dec) idf = idf | sm83_pkg::FN | ((i_val[3:0] == 4'h0) ? sm83_pkg::FH : 4'd0);
        else       idf = idf | ((i_val[3:0] == 4'hF) ? sm83_pkg::FH : 4'd0);
        if (idr == 8'd0) idf = idf | sm83_pkg::FZ;
        o_incdec = '{res: idr, flags: idf};

        // decimal adjust, subtraction keeps carry
        da = {1'b0, i_acc};
        dc = i_flags[0];
        if (i_flags[2]) begin
            if (dc) da = da - 9'h060;
            if (i_flags[1]) da = da - 9'h006;
        end else begin
            if (dc || i_acc > 8'h99) begin da = da + 9'h060; dc = 1'b1; end
            if (i_flags[1] || da[3:0] > 4'h9) da = da + 9'h006;
        end
        o_daa = '{res: da[7:0],
                  flags: ((da[7:0] == 8'd0) ? sm83_pkg::FZ : 4'd0)
                       | (i_flags & sm83_pkg::FN) | {3'd0, dc}};
    end
endmodule

// ===== design/sm83_load_alu_executor.sv =====
// top level: sm83 load/alu core driven one bus cycle per item
// Each input item is the byte returned for the previous bus request and each
// output item is the next request (read, write or internal idle) with the
// accumulator and flags after that cycle. One item is taken per clock: the
// whole machine-cycle step (decode of the latched opcode and phase, register
// file update, alu) is one pass of logic into the result register, and the
// input is taken whenever the result register is empty or being drained.
// Instructions take one bus item per machine cycle. An unknown opcode stops
// the core; every later item answers idle with illegal set until reset. Writes
// of start_pc/start_sp before the first item also reload the program
// counter or stack pointer.
`timescale 1ns / 1ps
module sm83_load_alu_executor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] read_data
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] bus_address, [23:16] bus_write_data,
                                        // [25:24] bus_kind, [26] instr_done,
                                        // [27] illegal, [35:28] acc_value,
                                        // [39:36] flag_bits
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    // architectural state
    logic [15:0] r_start_pc, r_start_sp;
    logic [7:0]  r_acc, n_acc;
    logic [3:0]  r_flags, n_flags;
    logic [7:0]  r_gp [6];
    logic [7:0]  n_gp [6];
    logic [15:0] r_sp, n_sp, r_pc, n_pc;
    logic [7:0]  r_op, n_op, r_lo, n_lo, r_hi, n_hi;
    logic [2:0]  r_ph, n_ph;
    logic        r_stop, n_stop;
    logic        r_ovalid;
    logic [39:0] r_odata;

    logic        accept, cfg_wr, fresh;
    logic [15:0] o_addr;
    logic [7:0]  o_wdata;
    logic [1:0]  o_kind;
    logic        o_done;

    // alu hookup
    logic [2:0]  alu_kind;
    logic [7:0]  alu_val, id_val;
    sm83_pkg::t_alu_out alu_o, id_o, daa_o;

    assign pready        = 1'b1;
    assign s_axis_tready = !r_ovalid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_wr        = psel && penable && pwrite;
    assign fresh         = (r_ph == 3'd0) && !r_stop;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_comb begin
        case (paddr[2])
            1'b0:    prdata = {16'd0, r_start_pc};
            default: prdata = {16'd0, r_start_sp};
        endcase
    end

    sm83_alu u_alu (
        .i_kind(alu_kind), .i_acc(r_acc), .i_val(alu_val), .i_flags(r_flags),
        .i_dec(n_op[0]), .o_alu(alu_o), .o_incdec(id_o), .o_daa(daa_o)
    );

    // step logic
    logic [7:0]  d, srcv;
    logic [2:0]  x, y, ph;
    logic [1:0]  p;
    logic [15:0] hlv, ptr, pv16, a16, ld16, ext;
    logic [8:0]  losum;
    logic [4:0]  lohs;

    always_comb begin
        d  = s_axis_tdata;
        n_acc = r_acc; n_flags = r_flags; n_gp = r_gp; n_sp = r_sp; n_pc = r_pc;
        n_op = r_op; n_lo = r_lo; n_hi = r_hi; n_ph = r_ph; n_stop = r_stop;
        o_addr = 16'd0; o_wdata = 8'd0; o_kind = sm83_pkg::KIND_IDLE; o_done = 1'b0;
        if (r_ph == 3'd1) n_op = d;
        x  = n_op[5:3];
        y  = n_op[2:0];
        p  = n_op[5:4];
        ph = r_ph;
        hlv  = {r_gp[4], r_gp[5]};
        a16  = {r_hi, r_lo};
        ld16 = {d, r_lo};
        ext  = {{8{d[7]}}, d};
        losum = {1'b0, r_sp[7:0]} + {1'b0, d};
        lohs  = {1'b0, r_sp[3:0]} + {1'b0, d[3:0]};
        srcv = (y == 3'd7) ? r_acc : ((y == 3'd6) ? 8'd0 : r_gp[y]);
        case (p)
            2'd0:    ptr = {r_gp[0], r_gp[1]};
            2'd1:    ptr = {r_gp[2], r_gp[3]};
            default: ptr = hlv;
        endcase
        case (p)
            2'd0:    pv16 = {r_gp[0], r_gp[1]};
            2'd1:    pv16 = {r_gp[2], r_gp[3]};
            2'd2:    pv16 = hlv;
            default: pv16 = {r_acc, r_flags, 4'd0};
        endcase
        alu_kind = x;
        alu_val  = (y == 3'd6 || n_op[7:6] == 2'b11) ? d : srcv;
        id_val   = (x == 3'd6) ? d : ((x == 3'd7) ? r_acc : r_gp[x]);
        if (!((n_op & 8'hC6) == 8'h04)) id_val = alu_val;
        if ((n_op & 8'hC6) == 8'h04) alu_val = id_val;

        if (r_stop) begin
            // stopped: idle forever
        end else if (r_ph == 3'd0) begin
            o_addr = r_pc; o_kind = sm83_pkg::KIND_READ; o_done = 1'b1;
            n_pc = r_pc + 16'd1; n_ph = 3'd1;
        end else begin
            n_ph = r_ph + 3'd1;
            if (n_op[7:6] == 2'b01 && n_op != 8'h76) begin
                if (y == 3'd6) begin
                    if (ph == 3'd1) begin o_addr = hlv; o_kind = sm83_pkg::KIND_READ; end
                    else begin
                        if (x == 3'd7) n_acc = d; else if (x < 3'd6) n_gp[x] = d;
                        n_ph = 3'd0;
                    end
                end else if (x == 3'd6) begin
                    if (ph == 3'd1) begin
                        o_addr = hlv; o_wdata = srcv; o_kind = sm83_pkg::KIND_WRITE;
                    end else n_ph = 3'd0;
                end else begin
                    if (x == 3'd7) n_acc = srcv; else n_gp[x] = srcv;
                    n_ph = 3'd0;
                end
            end else if (n_op[7:6] == 2'b10) begin
                if (y == 3'd6 && ph == 3'd1) begin
                    o_addr = hlv; o_kind = sm83_pkg::KIND_READ;
                end else begin
                    n_flags = alu_o.flags;
                    if (x != 3'd7) n_acc = alu_o.res;
                    n_ph = 3'd0;
                end
            end else if ((n_op & 8'hC7) == 8'hC6) begin
                if (ph == 3'd1) begin
                    o_addr = r_pc; o_kind = sm83_pkg::KIND_READ; n_pc = r_pc + 16'd1;
                end else begin
                    n_flags = alu_o.flags;
                    if (x != 3'd7) n_acc = alu_o.res;
                    n_ph = 3'd0;
                end
            end else if ((n_op & 8'hC7) == 8'h06) begin
                if (ph == 3'd1) begin
                    o_addr = r_pc; o_kind = sm83_pkg::KIND_READ; n_pc = r_pc + 16'd1;
                end else if (x == 3'd6 && ph == 3'd2) begin
                    o_addr = hlv; o_wdata = d; o_kind = sm83_pkg::KIND_WRITE;
                end else begin
                    if (x == 3'd7) n_acc = d; else if (x < 3'd6) n_gp[x] = d;
                    n_ph = 3'd0;
                end
            end else if ((n_op & 8'hC6) == 8'h04) begin
                if (x == 3'd6) begin
                    if (ph == 3'd1) begin o_addr = hlv; o_kind = sm83_pkg::KIND_READ; end
                    else if (ph == 3'd2) begin
                        n_flags = id_o.flags;
                        o_addr = hlv; o_wdata = id_o.res; o_kind = sm83_pkg::KIND_WRITE;
                    end else n_ph = 3'd0;
                end else begin
                    n_flags = id_o.flags;
                    if (x == 3'd7) n_acc = id_o.res; else n_gp[x] = id_o.res;
                    n_ph = 3'd0;
                end
            end else if ((n_op & 8'hCF) == 8'h02 || (n_op & 8'hCF) == 8'h0A) begin
                if (ph == 3'd1) begin
                    o_addr = ptr;
                    if (p == 2'd2) {n_gp[4], n_gp[5]} = hlv + 16'd1;
                    if (p == 2'd3) {n_gp[4], n_gp[5]} = hlv - 16'd1;
                    if (n_op[3]) o_kind = sm83_pkg::KIND_READ;
                    else begin o_wdata = r_acc; o_kind = sm83_pkg::KIND_WRITE; end
                end else begin
                    if (n_op[3]) n_acc = d;
                    n_ph = 3'd0;
                end
            end else if ((n_op & 8'hCF) == 8'h01) begin
                if (ph == 3'd1 || ph == 3'd2) begin
                    if (ph == 3'd2) n_lo = d;
                    o_addr = r_pc; o_kind = sm83_pkg::KIND_READ; n_pc = r_pc + 16'd1;
                end else begin
                    case (p)
                        2'd0: {n_gp[0], n_gp[1]} = ld16;
                        2'd1: {n_gp[2], n_gp[3]} = ld16;
                        2'd2: {n_gp[4], n_gp[5]} = ld16;
                        default: n_sp = ld16;
                    endcase
                    n_ph = 3'd0;
                end
            end else if ((n_op & 8'hCF) == 8'hC1) begin
                if (ph == 3'd1 || ph == 3'd2) begin
                    if (ph == 3'd2) n_lo = d;
                    o_addr = r_sp; o_kind = sm83_pkg::KIND_READ; n_sp = r_sp + 16'd1;
                end else begin
                    case (p)
                        2'd0: {n_gp[0], n_gp[1]} = ld16;
                        2'd1: {n_gp[2], n_gp[3]} = ld16;
                        2'd2: {n_gp[4], n_gp[5]} = ld16;
                        default: begin n_acc = d; n_flags = r_lo[7:4]; end
                    endcase
                    n_ph = 3'd0;
                end
            end else if ((n_op & 8'hCF) == 8'hC5) begin
                if (ph == 3'd1 || ph == 3'd2) begin
                    n_sp = r_sp - 16'd1;
                    o_addr = n_sp; o_kind = sm83_pkg::KIND_WRITE;
                    o_wdata = (ph == 3'd1) ? pv16[15:8] : pv16[7:0];
                end else n_ph = 3'd0;
            end else if (n_op == 8'h08) begin
                if (ph == 3'd1 || ph == 3'd2) begin
                    if (ph == 3'd2) n_lo = d;
                    o_addr = r_pc; o_kind = sm83_pkg::KIND_READ; n_pc = r_pc + 16'd1;
                end else if (ph == 3'd3) begin
                    n_hi = d; o_addr = ld16; o_wdata = r_sp[7:0];
                    o_kind = sm83_pkg::KIND_WRITE;
                end else if (ph == 3'd4) begin
                    o_addr = a16 + 16'd1; o_wdata = r_sp[15:8];
                    o_kind = sm83_pkg::KIND_WRITE;
                end else n_ph = 3'd0;
            end else if (n_op == 8'h27) begin
                n_acc = daa_o.res; n_flags = daa_o.flags; n_ph = 3'd0;
            end else if (n_op == 8'h2F) begin
                n_acc = ~r_acc; n_flags = r_flags | sm83_pkg::FN | sm83_pkg::FH; n_ph = 3'd0;
            end else if (n_op == 8'h37) begin
                n_flags = (r_flags & sm83_pkg::FZ) | sm83_pkg::FC; n_ph = 3'd0;
            end else if (n_op == 8'h3F) begin
                n_flags = (r_flags & sm83_pkg::FZ) | ((r_flags & sm83_pkg::FC) ^ sm83_pkg::FC);
                n_ph = 3'd0;
            end else if (n_op == 8'hE0 || n_op == 8'hF0) begin
                if (ph == 3'd1) begin
                    o_addr = r_pc; o_kind = sm83_pkg::KIND_READ; n_pc = r_pc + 16'd1;
                end else if (ph == 3'd2) begin
                    o_addr = sm83_pkg::HIGH_PAGE | {8'd0, d};
                    if (n_op[4]) o_kind = sm83_pkg::KIND_READ;
                    else begin o_wdata = r_acc; o_kind = sm83_pkg::KIND_WRITE; end
                end else begin
                    if (n_op[4]) n_acc = d;
                    n_ph = 3'd0;
                end
            end else if (n_op == 8'hE2 || n_op == 8'hF2) begin
                if (ph == 3'd1) begin
                    o_addr = sm83_pkg::HIGH_PAGE | {8'd0, r_gp[1]};
                    if (n_op[4]) o_kind = sm83_pkg::KIND_READ;
                    else begin o_wdata = r_acc; o_kind = sm83_pkg::KIND_WRITE; end
                end else begin
                    if (n_op[4]) n_acc = d;
                    n_ph = 3'd0;
                end
            end else if (n_op == 8'hEA || n_op == 8'hFA) begin
                if (ph == 3'd1 || ph == 3'd2) begin
                    if (ph == 3'd2) n_lo = d;
                    o_addr = r_pc; o_kind = sm83_pkg::KIND_READ; n_pc = r_pc + 16'd1;
                end else if (ph == 3'd3) begin
                    n_hi = d; o_addr = ld16;
                    if (n_op[4]) o_kind = sm83_pkg::KIND_READ;
                    else begin o_wdata = r_acc; o_kind = sm83_pkg::KIND_WRITE; end
                end else begin
                    if (n_op[4]) n_acc = d;
                    n_ph = 3'd0;
                end
            end else if (n_op == 8'hF8) begin
                if (ph == 3'd1) begin
                    o_addr = r_pc; o_kind = sm83_pkg::KIND_READ; n_pc = r_pc + 16'd1;
                end else if (ph == 3'd2) begin
                    // sign from bit 7, h/c from the low byte add
                    n_flags = (lohs[4] ? sm83_pkg::FH : 4'd0) | (losum[8] ? sm83_pkg::FC : 4'd0);
                    {n_gp[4], n_gp[5]} = r_sp + ext;
                end else n_ph = 3'd0;
            end else if (n_op == 8'hF9) begin
                if (ph == 3'd1) n_sp = hlv;
                else n_ph = 3'd0;
            end else begin
                n_stop = 1'b1;
                n_ph = r_ph;
            end
            // finishing an instruction issues the next opcode fetch
            if (n_ph == 3'd0 && !n_stop) begin
                o_addr = n_pc; o_wdata = 8'd0; o_kind = sm83_pkg::KIND_READ; o_done = 1'b1;
                n_pc = n_pc + 16'd1; n_ph = 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pc <= 16'd256;
            r_start_sp <= 16'd65534;
            r_acc <= 8'd0; r_flags <= 4'd0;
            for (int i = 0; i < 6; i++) r_gp[i] <= 8'd0;
            r_sp <= 16'd65534; r_pc <= 16'd256;
            r_op <= 8'd0; r_lo <= 8'd0; r_hi <= 8'd0; r_ph <= 3'd0;
            r_stop <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_acc <= n_acc; r_flags <= n_flags; r_gp <= n_gp;
                r_sp <= n_sp; r_pc <= n_pc; r_op <= n_op; r_lo <= n_lo;
                r_hi <= n_hi; r_ph <= n_ph; r_stop <= n_stop;
                r_ovalid <= 1'b1;
                r_odata <= {n_flags, n_acc, n_stop, o_done & !n_stop,
                            n_stop ? sm83_pkg::KIND_IDLE : o_kind,
                            n_stop ? 8'd0 : o_wdata, n_stop ? 16'd0 : o_addr};
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_wr) begin
                if (paddr[2] == sm83_pkg::REG_START_PC[0]) begin
                    r_start_pc <= pwdata[15:0];
                    if (fresh) r_pc <= pwdata[15:0];
                end else if (paddr[2] == sm83_pkg::REG_START_SP[0]) begin
                    r_start_sp <= pwdata[15:0];
                    if (fresh) r_sp <= pwdata[15:0];
                end
            end
        end
    end

    // a stopped core only ever reports idle requests
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[27]) |-> (m_axis_tdata[25:24] == sm83_pkg::KIND_IDLE))
        else $error("stopped core issued a bus access");
    // an opcode fetch is always a read
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[26]) |-> (m_axis_tdata[25:24] == sm83_pkg::KIND_READ))
        else $error("fetch not a read");
    // stopped is sticky until reset
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop |=> r_stop) else $error("stop flag cleared");
endmodule
